// ----- hw/rtl/tlb_lru_pkg.sv -----
package tlb_lru_pkg;

   // action codes carried on req_tuser
   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_FILL   = 1'b1;

   // per-beat command broadcast to every cell
   typedef struct packed {
      logic lookup;
      logic fill;
   } tlb_lru_cmd_type;

endpackage

// ----- hw/rtl/tlb_lru_cell.sv -----
module tlb_lru_cell
   import tlb_lru_pkg::*;
#(
   parameter int ENTRIES    = 4,
   parameter int TAG_BITS   = 19,
   parameter int FRAME_BITS = 19,
   parameter int RANK_BITS  = 2,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tlb_lru_cmd_type       cmd,
   input  logic [TAG_BITS-1:0]   tag,
   input  logic [FRAME_BITS-1:0] fill_frame,
   input  logic                  update,
   input  logic [RANK_BITS-1:0]  win_rank,
   input  logic                  taken_up,
   input  logic [RANK_BITS-1:0]  slot_up,
   input  logic [FRAME_BITS-1:0] frame_up,
   input  logic [RANK_BITS-1:0]  rank_up,
   output logic                  taken_out,
   output logic [RANK_BITS-1:0]  slot_out,
   output logic [FRAME_BITS-1:0] frame_out,
   output logic [RANK_BITS-1:0]  rank_out
);

   localparam logic [RANK_BITS-1:0] TopRank = RANK_BITS'(ENTRIES - 1);

   logic [TAG_BITS-1:0]   tag_ff,   tag_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic                  valid_ff, valid_in;
   logic [RANK_BITS-1:0]  rank_ff,  rank_in;
   logic                  cond;
   logic                  win;

   // lookup matches a valid tag, fill picks the least recently used entry
   always_comb begin
      cond = (cmd.lookup & valid_ff & (tag_ff == tag)) |
             (cmd.fill & (rank_ff == '0));
      win  = cond & ~taken_up;
   end

   // lowest-numbered winner claims the chain
   always_comb begin
      taken_out = taken_up | cond;
      slot_out  = win ? RANK_BITS'(INDEX) : slot_up;
      frame_out = win ? (cmd.fill ? fill_frame : frame_ff) : frame_up;
      rank_out  = win ? rank_ff : rank_up;
   end

   always_comb begin
      tag_in   = tag_ff;
      frame_in = frame_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (update) begin
         if (win) begin
            rank_in = TopRank;
         end else if (rank_ff > win_rank) begin
            rank_in = rank_ff - RANK_BITS'(1);
         end
         if (win && cmd.fill) begin
            tag_in   = tag;
            frame_in = fill_frame;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= RANK_BITS'(INDEX);
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      frame_ff <= frame_in;
   end

endmodule

// ----- hw/rtl/tlb_lru_lookup_fill.sv -----
// channel | direction | handshake             | tuser  | tdata (low bit up)
// req_    | in        | req_tvalid/req_tready | action | tag, fill_frame
// rsp_    | out       | rsp_tvalid/rsp_tready | hit    | frame, slot
//
// each beat is resolved combinationally: the compare result ripples through the
// row of entry cells and the ranks update at the same edge the result is registered.
// one beat per cycle while rsp_tready stays high; a stalled result holds the
// input off only until it is taken.
// reset clears all valid bits and sets each entry's rank to its index.
module tlb_lru_lookup_fill
   import tlb_lru_pkg::*;
#(
   parameter int ENTRIES    = 4,
   parameter int TAG_BITS   = 19,
   parameter int FRAME_BITS = 19,
   localparam int SLOT_BITS = $clog2(ENTRIES),
   localparam int REQ_BITS  = ((TAG_BITS + FRAME_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = ((FRAME_BITS + SLOT_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,  // tag, fill_frame, zero pad
   input  logic                req_tuser,  // action
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,  // frame, slot, zero pad
   output logic                rsp_tuser   // hit
);

   logic                  accept;
   tlb_lru_cmd_type       cmd;
   logic [TAG_BITS-1:0]   req_tag;
   logic [FRAME_BITS-1:0] req_frame;
   logic                  upd;

   logic                  chain_taken [ENTRIES+1];
   logic [SLOT_BITS-1:0]  chain_slot  [ENTRIES+1];
   logic [FRAME_BITS-1:0] chain_frame [ENTRIES+1];
   logic [SLOT_BITS-1:0]  chain_rank  [ENTRIES+1];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff,   rsp_hit_in;
   logic [FRAME_BITS-1:0] rsp_frame_ff, rsp_frame_in;
   logic [SLOT_BITS-1:0]  rsp_slot_ff,  rsp_slot_in;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign req_tag    = req_tdata[TAG_BITS-1:0];
   assign req_frame  = req_tdata[TAG_BITS +: FRAME_BITS];

   always_comb begin
      cmd.lookup = accept & (req_tuser == ACT_LOOKUP);
      cmd.fill   = accept & (req_tuser == ACT_FILL);
   end

   assign chain_taken[0] = 1'b0;
   assign chain_slot[0]  = '0;
   assign chain_frame[0] = '0;
   assign chain_rank[0]  = '0;

   // ranks move only when some cell won the chain
   assign upd = chain_taken[ENTRIES] & (cmd.lookup | cmd.fill);

   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      tlb_lru_cell #(
         .ENTRIES    (ENTRIES),
         .TAG_BITS   (TAG_BITS),
         .FRAME_BITS (FRAME_BITS),
         .RANK_BITS  (SLOT_BITS),
         .INDEX      (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .tag        (req_tag),
         .fill_frame (req_frame),
         .update     (upd),
         .win_rank   (chain_rank[ENTRIES]),
         .taken_up   (chain_taken[k]),
         .slot_up    (chain_slot[k]),
         .frame_up   (chain_frame[k]),
         .rank_up    (chain_rank[k]),
         .taken_out  (chain_taken[k+1]),
         .slot_out   (chain_slot[k+1]),
         .frame_out  (chain_frame[k+1]),
         .rank_out   (chain_rank[k+1])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = cmd.lookup & chain_taken[ENTRIES];
         if (cmd.fill) begin
            rsp_frame_in = req_frame;
            rsp_slot_in  = chain_slot[ENTRIES];
         end else begin
            rsp_frame_in = chain_frame[ENTRIES];
            rsp_slot_in  = chain_slot[ENTRIES];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff   <= rsp_hit_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_slot_ff, rsp_frame_ff});

endmodule
